/* rtl/jdg_pkg.sv */
// ----------------------------------------------------------------------------
// jdg_pkg
// Shared constants, widths and tables for the Julian date to calendar date
// converter.
// ----------------------------------------------------------------------------
package jdg_pkg;

   // first day of the Gregorian calendar
   localparam int GREG_START     = 2299161;

   // (4Z - ALPHA_OFS) / ALPHA_DIV gives the century correction
   localparam int ALPHA_OFS      = 7468865;
   localparam int ALPHA_DIV      = 146097;

   // B = A + B_OFS, C = (20B - C_OFS) / C_DIV
   localparam int B_OFS          = 1524;
   localparam int C_MUL          = 20;
   localparam int C_OFS          = 2442;
   localparam int C_DIV          = 7305;

   // D = (D_MUL * C) / 4
   localparam int D_MUL          = 1461;
   localparam int D_MUL_W        = 11;

   // E = E_SCALE (B - D) / E_DIV
   localparam int E_SCALE        = 10000;
   localparam int E_DIV          = 306001;
   localparam int E_WRAP         = 14;

   // year offsets for months after / up to February
   localparam int YEAR_OFS_LATE  = 4716;
   localparam int YEAR_OFS_EARLY = 4715;
   localparam int MONTH_FEB      = 2;

   // time of day
   localparam int DAY_SECS       = 86400;
   localparam int SIXTY          = 60;

   // field and intermediate widths
   localparam int YEAR_W         = 14;
   localparam int MONTH_W        = 4;
   localparam int DOM_W          = 5;
   localparam int HOUR_W         = 5;
   localparam int MIN_W          = 6;
   localparam int SEC_OUT_W      = 6;
   localparam int SFRAC_W        = 32;
   localparam int SEC_W          = 17;   // seconds of the day, below 86400
   localparam int MT_W           = 11;   // minutes of the day, below 1440
   localparam int BD_W           = 9;    // B - D, below 490
   localparam int N3_W           = 23;   // E_SCALE * (B - D)
   localparam int E_W            = 5;
   localparam int EDAY_W         = 10;

   // floor(30.6001 * e) for every code of e
   localparam logic [EDAY_W-1:0] E_DAYS [2**E_W] = '{
      10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
      10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459,
      10'd489, 10'd520, 10'd550, 10'd581, 10'd612, 10'd642, 10'd673, 10'd703,
      10'd734, 10'd765, 10'd795, 10'd826, 10'd856, 10'd887, 10'd918, 10'd948
   };

   // width of the quotient of a num_w-bit value by a constant divisor
   function automatic int quo_width(input int num_w, input int divisor);
      return num_w - ($clog2(divisor + 1) - 1);
   endfunction

endpackage

/* rtl/jdg_cdiv.sv */
// ----------------------------------------------------------------------------
// jdg_cdiv
// Two-stage divider by a constant: reciprocal multiply, then one
// multiply-back and correction step. Sideband data rides along.
// ----------------------------------------------------------------------------
module jdg_cdiv #(
   parameter int DIVISOR = 60,
   parameter int NUM_W   = 17,
   parameter int SIDE_W  = 1,
   localparam int Q_W    = jdg_pkg::quo_width(NUM_W, DIVISOR)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  logic [NUM_W-1:0]  num_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [Q_W-1:0]    quo_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam longint unsigned RECIP_L = (64'd1 << NUM_W) / DIVISOR;
   localparam logic [Q_W-1:0] RECIP = Q_W'(RECIP_L);
   localparam int P_W = NUM_W + Q_W;

   logic              valid1_ff;
   logic [NUM_W-1:0]  num1_ff;
   logic [Q_W-1:0]    est1_ff;
   logic [Q_W-1:0]    est1_in;
   logic [SIDE_W-1:0] side1_ff;
   logic [P_W-1:0]    prod;

   logic              valid2_ff;
   logic [Q_W-1:0]    quo2_ff;
   logic [Q_W-1:0]    quo2_in;
   logic [SIDE_W-1:0] side2_ff;
   logic [NUM_W-1:0]  back;
   logic [NUM_W-1:0]  rem;

   // estimate, low by at most one
   always_comb begin
      prod    = P_W'(num_in) * P_W'(RECIP);
      est1_in = prod[NUM_W +: Q_W];
   end

   // multiply back and correct
   always_comb begin
      back    = NUM_W'(est1_ff) * NUM_W'(DIVISOR);
      rem     = num1_ff - back;
      quo2_in = (rem >= NUM_W'(DIVISOR)) ? est1_ff + Q_W'(1) : est1_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      num1_ff  <= num_in;
      est1_ff  <= est1_in;
      side1_ff <= side_in;
      quo2_ff  <= quo2_in;
      side2_ff <= side1_ff;
   end

   assign valid_out = valid2_ff;
   assign quo_out   = quo2_ff;
   assign side_out  = side2_ff;

endmodule

/* rtl/julian_date_to_gregorian.sv */
// ----------------------------------------------------------------------------
// julian_date_to_gregorian
// Converts a fixed-point Julian date to calendar date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_julian_date and raise start; a transaction is taken at
//   every rising edge with start high and busy low. busy is low except while
//   reset is high, so one transaction can enter every cycle.
//   Output: each transaction gives one result, shown for one cycle with
//   rsp_strobe high. Results come out in the order the transactions went in.
//   Throughput is one transaction per cycle while reset is low. Latency is
//   set by three chained constant dividers (century correction, year, month),
//   each two stages, plus the adds and constant multiplies between them.
//   Julian calendar is used below day 2299161, Gregorian from it on.
//   Reset (synchronous) drops every transaction in flight; no result follows.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module julian_date_to_gregorian #(
   parameter int DAY_BITS  = 22,
   parameter int FRAC_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [DAY_BITS+FRAC_BITS-1:0] req_julian_date,
   output logic                          rsp_strobe,
   output logic signed [13:0]            rsp_year,
   output logic [3:0]                    rsp_month,
   output logic [4:0]                    rsp_day_of_month,
   output logic [4:0]                    rsp_hour,
   output logic [5:0]                    rsp_minute,
   output logic [5:0]                    rsp_second,
   output logic [31:0]                   rsp_second_fraction
);

   import jdg_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int Z_W    = DAY_BITS + 1;
   localparam int N1_W   = DAY_BITS + 3;
   localparam int A_W    = quo_width(N1_W, ALPHA_DIV);
   localparam int B_W    = DAY_BITS + 1;
   localparam int N2_W   = DAY_BITS + 5;
   localparam int C_W    = quo_width(N2_W, C_DIV);
   localparam int MTQ_W  = quo_width(SEC_W, SIXTY);
   localparam int HRQ_W  = quo_width(MT_W, SIXTY);
   localparam int EQ_W   = quo_width(N3_W, E_DIV);
   localparam int SC_W   = F + SEC_W;
   localparam int DP_W   = C_W + D_MUL_W;

   typedef struct packed {
      logic [Z_W-1:0] z;
      logic           greg;
   } alpha_side_type;

   typedef struct packed {
      logic [SEC_W-1:0] secs;
      logic [F-1:0]     subsec;
   } mt_side_type;

   typedef struct packed {
      logic [MT_W-1:0]      mt;
      logic [SEC_OUT_W-1:0] sec;
      logic [F-1:0]         subsec;
   } hr_side_type;

   typedef struct packed {
      logic [BD_W-1:0]      bd;
      logic [C_W-1:0]       c;
      logic [HOUR_W-1:0]    hour;
      logic [MIN_W-1:0]     minute;
      logic [SEC_OUT_W-1:0] sec;
      logic [F-1:0]         subsec;
   } e_side_type;

   // stage 1: split into day number and fraction from midnight
   logic           accept;
   logic [F:0]     frac_sum;
   logic           v1_ff;
   logic [Z_W-1:0] z1_ff, z1_in;
   logic [F-1:0]   frac1_ff;

   // stage 2: century numerator and seconds of the day
   logic            v2_ff;
   logic [Z_W-1:0]  z2_ff;
   logic            greg2_ff, greg2_in;
   logic [N1_W-1:0] n1_2_ff, n1_2_in;
   logic [SC_W-1:0] scaled2_ff, scaled2_in;

   // stages 3-4: alpha and minutes of the day
   alpha_side_type  a_side_in, a_side_out;
   mt_side_type     mt_side_in, mt_side_out;
   logic            v4;
   logic [A_W-1:0]  alpha4;
   logic [MTQ_W-1:0] mt4;

   // stage 5: B and whole seconds
   logic                 v5_ff;
   logic [B_W-1:0]       b5_ff, b5_in;
   logic [MT_W-1:0]      mt5_ff;
   logic [SEC_OUT_W-1:0] sec5_ff, sec5_in;
   logic [F-1:0]         subsec5_ff;
   logic [SEC_W-1:0]     mt_back;

   // stage 6: year numerator
   logic                 v6_ff;
   logic [N2_W-1:0]      n2_6_ff, n2_6_in;
   logic [B_W-1:0]       b6_ff;
   hr_side_type          hr6_ff, hr6_in;

   // stages 7-8: C and hours
   logic                 v8;
   logic [C_W-1:0]       c8;
   logic [B_W-1:0]       b8;
   logic [HRQ_W-1:0]     hour8;
   hr_side_type          hr8;

   // stage 9: B - D and minutes
   logic                 v9_ff;
   e_side_type           e9_ff, e9_in;
   logic [DP_W-1:0]      d_full;
   logic [MT_W-1:0]      hr_back;

   // stage 10: month numerator
   logic                 v10_ff;
   logic [N3_W-1:0]      n3_10_ff, n3_10_in;
   e_side_type           e10_ff;

   // stages 11-12: E
   logic                 v12;
   logic [EQ_W-1:0]      e12;
   e_side_type           e12_side;

   // stage 13: result
   logic                 strobe_ff;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DOM_W-1:0]     dom_ff, dom_in;
   logic [HOUR_W-1:0]    hour_ff;
   logic [MIN_W-1:0]     minute_ff;
   logic [SEC_OUT_W-1:0] second_ff;
   logic [SFRAC_W-1:0]   sfrac_ff, sfrac_in;
   logic [EDAY_W-1:0]    bd_ext;

   // the pipeline never stalls; hold off only during reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // add half a day, carry into the day number
   always_comb begin
      frac_sum = {1'b0, req_julian_date[F-1:0]} + ((F+1)'(1) << (F - 1));
      z1_in    = Z_W'(req_julian_date[F +: DAY_BITS]) + Z_W'(frac_sum[F]);
   end

   // century numerator (zero before the Gregorian start) and fraction * 86400
   always_comb begin
      greg2_in   = (z1_ff >= Z_W'(GREG_START));
      n1_2_in    = greg2_in ? N1_W'({z1_ff, 2'b00}) - N1_W'(ALPHA_OFS) : '0;
      scaled2_in = SC_W'(frac1_ff) * SC_W'(DAY_SECS);
   end

   assign a_side_in  = '{z: z2_ff, greg: greg2_ff};
   assign mt_side_in = '{secs: scaled2_ff[F +: SEC_W], subsec: scaled2_ff[F-1:0]};

   jdg_cdiv #(
      .DIVISOR (ALPHA_DIV),
      .NUM_W   (N1_W),
      .SIDE_W  ($bits(alpha_side_type))
   ) u_div_alpha (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v2_ff),
      .num_in    (n1_2_ff),
      .side_in   (a_side_in),
      .valid_out (v4),
      .quo_out   (alpha4),
      .side_out  (a_side_out)
   );

   jdg_cdiv #(
      .DIVISOR (SIXTY),
      .NUM_W   (SEC_W),
      .SIDE_W  ($bits(mt_side_type))
   ) u_div_min (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v2_ff),
      .num_in    (mt_side_in.secs),
      .side_in   (mt_side_in),
      .valid_out (),
      .quo_out   (mt4),
      .side_out  (mt_side_out)
   );

   // B = Z + 1524, plus 1 + alpha - alpha/4 in the Gregorian range
   always_comb begin
      b5_in   = B_W'(a_side_out.z) + B_W'(B_OFS) + B_W'(a_side_out.greg)
              + B_W'(alpha4) - B_W'(alpha4 >> 2);
      mt_back = SEC_W'(mt4) * SEC_W'(SIXTY);
      sec5_in = SEC_OUT_W'(mt_side_out.secs - mt_back);
   end

   // year numerator 20B - 2442
   always_comb begin
      n2_6_in = N2_W'(b5_ff) * N2_W'(C_MUL) - N2_W'(C_OFS);
      hr6_in  = '{mt: mt5_ff, sec: sec5_ff, subsec: subsec5_ff};
   end

   jdg_cdiv #(
      .DIVISOR (C_DIV),
      .NUM_W   (N2_W),
      .SIDE_W  (B_W)
   ) u_div_year (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v6_ff),
      .num_in    (n2_6_ff),
      .side_in   (b6_ff),
      .valid_out (v8),
      .quo_out   (c8),
      .side_out  (b8)
   );

   jdg_cdiv #(
      .DIVISOR (SIXTY),
      .NUM_W   (MT_W),
      .SIDE_W  ($bits(hr_side_type))
   ) u_div_hour (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v6_ff),
      .num_in    (hr6_ff.mt),
      .side_in   (hr6_ff),
      .valid_out (),
      .quo_out   (hour8),
      .side_out  (hr8)
   );

   // D = 1461 C / 4, days left in the year, minute of the hour
   always_comb begin
      d_full          = DP_W'(c8) * DP_W'(D_MUL);
      hr_back         = MT_W'(hour8) * MT_W'(SIXTY);
      e9_in.bd        = BD_W'(b8) - d_full[BD_W+1:2];
      e9_in.c         = c8;
      e9_in.hour      = HOUR_W'(hour8);
      e9_in.minute    = MIN_W'(hr8.mt - hr_back);
      e9_in.sec       = hr8.sec;
      e9_in.subsec    = hr8.subsec;
   end

   // month numerator 10000 (B - D)
   assign n3_10_in = N3_W'(e9_ff.bd) * N3_W'(E_SCALE);

   jdg_cdiv #(
      .DIVISOR (E_DIV),
      .NUM_W   (N3_W),
      .SIDE_W  ($bits(e_side_type))
   ) u_div_month (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v10_ff),
      .num_in    (n3_10_ff),
      .side_in   (e10_ff),
      .valid_out (v12),
      .quo_out   (e12),
      .side_out  (e12_side)
   );

   // day, month and year from E
   always_comb begin
      bd_ext   = EDAY_W'(e12_side.bd);
      dom_in   = DOM_W'(bd_ext - E_DAYS[E_W'(e12)]);
      month_in = (e12 < EQ_W'(E_WRAP)) ? MONTH_W'(e12 - EQ_W'(1))
                                       : MONTH_W'(e12 - EQ_W'(E_WRAP - 1));
      year_in  = (month_in > MONTH_W'(MONTH_FEB))
               ? YEAR_W'(e12_side.c) - YEAR_W'(YEAR_OFS_LATE)
               : YEAR_W'(e12_side.c) - YEAR_W'(YEAR_OFS_EARLY);
   end

   // sub-second fraction scaled to 32 bits
   generate
      if (F >= SFRAC_W) begin : g_frac_trunc
         assign sfrac_in = e12_side.subsec[F-1 -: SFRAC_W];
      end else begin : g_frac_pad
         assign sfrac_in = {e12_side.subsec, {(SFRAC_W-F){1'b0}}};
      end
   endgenerate

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         v6_ff     <= 1'b0;
         v9_ff     <= 1'b0;
         v10_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= accept;
         v2_ff     <= v1_ff;
         v5_ff     <= v4;
         v6_ff     <= v5_ff;
         v9_ff     <= v8;
         v10_ff    <= v9_ff;
         strobe_ff <= v12;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      z1_ff      <= z1_in;
      frac1_ff   <= frac_sum[F-1:0];
      z2_ff      <= z1_ff;
      greg2_ff   <= greg2_in;
      n1_2_ff    <= n1_2_in;
      scaled2_ff <= scaled2_in;
      b5_ff      <= b5_in;
      mt5_ff     <= MT_W'(mt4);
      sec5_ff    <= sec5_in;
      subsec5_ff <= mt_side_out.subsec;
      n2_6_ff    <= n2_6_in;
      b6_ff      <= b5_ff;
      hr6_ff     <= hr6_in;
      e9_ff      <= e9_in;
      n3_10_ff   <= n3_10_in;
      e10_ff     <= e9_ff;
      year_ff    <= year_in;
      month_ff   <= month_in;
      dom_ff     <= dom_in;
      hour_ff    <= e12_side.hour;
      minute_ff  <= e12_side.minute;
      second_ff  <= e12_side.sec;
      sfrac_ff   <= sfrac_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_year            = year_ff;
   assign rsp_month           = month_ff;
   assign rsp_day_of_month    = dom_ff;
   assign rsp_hour            = hour_ff;
   assign rsp_minute          = minute_ff;
   assign rsp_second          = second_ff;
   assign rsp_second_fraction = sfrac_ff;

endmodule

/* rtl/jdg_monitor.sv */
// ----------------------------------------------------------------------------
// jdg_monitor
// Port-level checks on the converter: fixed latency, flush on reset and result ranges.
// ----------------------------------------------------------------------------
module jdg_monitor (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [3:0] rsp_month,
   input logic [4:0] rsp_day_of_month,
   input logic [4:0] rsp_hour,
   input logic [5:0] rsp_minute,
   input logic [5:0] rsp_second
);

   localparam int LATENCY = 13;

   // every accepted transaction returns after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing after accepted transaction");

   // no result without a matching accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without matching transaction");

   // a reset cycle leaves no result behind
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result right after reset");

   // calendar and clock fields stay in range
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                      rsp_day_of_month >= 5'd1 && rsp_hour <= 5'd23 &&
                      rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("result field out of range");

endmodule

bind julian_date_to_gregorian jdg_monitor u_monitor (.*);
